// ===== rtl/trbq_pkg.sv =====
package trbq_pkg;

    localparam int DEPTH   = 2048;
    localparam int ADDR_W  = $clog2(DEPTH);
    localparam int CNT_W   = ADDR_W + 1;
    localparam int LEN_W   = 16;
    localparam int DROP_W  = 32;
    localparam int BYTE_W  = 8;

    typedef enum logic [1:0] {
        CMD_ENQUEUE = 2'd0,
        CMD_TX_DONE = 2'd1,
        CMD_READ    = 2'd2,
        CMD_RSVD    = 2'd3
    } cmd_t;

    typedef enum logic [2:0] {
        ST_STORED  = 3'd0,
        ST_DROPPED = 3'd1,
        ST_DISCARD = 3'd2,
        ST_INVALID = 3'd3,
        ST_DONE    = 3'd4
    } status_t;

    typedef struct packed {
        logic              we;
        logic [ADDR_W-1:0] waddr;
        logic [BYTE_W-1:0] wdata;
        logic              re;
        logic [ADDR_W-1:0] raddr;
    } trbq_ram_req_t;

    typedef struct packed {
        status_t           status;
        logic              burst_start;
        logic [ADDR_W-1:0] burst_offset;
        logic [CNT_W-1:0]  burst_length;
        logic [DROP_W-1:0] dropped_bytes;
        logic [ADDR_W-1:0] used_bytes;
        logic              is_read;
    } trbq_result_t;

endpackage

// ===== rtl/trbq_ram.sv =====
module trbq_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 2048
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        if (re) begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

// ===== rtl/trbq_ctrl.sv =====
module trbq_ctrl
    import trbq_pkg::*;
(
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                cfg_write,
    input  logic                cfg_tx_enable,
    input  logic                accept,
    input  logic [1:0]          cmd,
    input  logic [BYTE_W-1:0]   data_byte,
    input  logic                first_of_message,
    input  logic [LEN_W-1:0]    message_length,
    input  logic [ADDR_W-1:0]   read_offset,
    output trbq_ram_req_t       ram_req,
    output trbq_result_t        result
);

    logic [ADDR_W-1:0] wr_idx_reg,  wr_idx_next;
    logic [ADDR_W-1:0] rd_idx_reg,  rd_idx_next;
    logic              busy_reg,    busy_next;
    logic [CNT_W-1:0]  size_reg,    size_next;
    logic [DROP_W-1:0] drop_reg,    drop_next;
    logic [LEN_W-1:0]  left_reg,    left_next;
    logic              discard_reg, discard_next;
    logic [ADDR_W-1:0] staged_reg,  staged_next;
    logic              tx_en_reg;

    logic [ADDR_W-1:0] used;
    logic [ADDR_W-1:0] free_space;
    logic [LEN_W-1:0]  left_dec;
    logic [LEN_W-1:0]  len_dec;
    logic              commit;
    logic [ADDR_W-1:0] commit_cnt;
    logic              retry;
    logic              start;
    status_t           status;

    always_comb begin
        wr_idx_next  = wr_idx_reg;
        rd_idx_next  = rd_idx_reg;
        busy_next    = busy_reg;
        size_next    = size_reg;
        drop_next    = drop_reg;
        left_next    = left_reg;
        discard_next = discard_reg;
        staged_next  = staged_reg;
        commit       = 1'b0;
        commit_cnt   = '0;
        retry        = 1'b0;
        start        = 1'b0;
        status       = ST_DONE;
        ram_req      = '0;
        used         = wr_idx_reg - rd_idx_reg;
        free_space   = ADDR_W'(DEPTH - 1) - used;
        left_dec     = left_reg - LEN_W'(1);
        len_dec      = message_length - LEN_W'(1);
        ram_req.wdata = data_byte;
        ram_req.raddr = rd_idx_reg + read_offset;

        if (accept) begin
            case (cmd_t'(cmd))
                CMD_ENQUEUE: begin
                    if (first_of_message) begin
                        staged_next  = '0;
                        left_next    = '0;
                        discard_next = 1'b0;
                        if (message_length == '0) begin
                            status = ST_INVALID;
                        end else if (32'(message_length) >= 32'(DEPTH) ||
                                     32'(message_length) > 32'(free_space)) begin
                            drop_next    = drop_reg + DROP_W'(message_length);
                            left_next    = len_dec;
                            discard_next = (len_dec != '0);
                            status       = ST_DROPPED;
                        end else begin
                            ram_req.we    = 1'b1;
                            ram_req.waddr = wr_idx_reg;
                            left_next     = len_dec;
                            staged_next   = ADDR_W'(1);
                            status        = ST_STORED;
                            if (len_dec == '0) begin
                                commit     = 1'b1;
                                commit_cnt = ADDR_W'(1);
                            end
                        end
                    end else if (left_reg == '0) begin
                        status = ST_INVALID;
                    end else if (discard_reg) begin
                        left_next    = left_dec;
                        discard_next = (left_dec != '0);
                        status       = ST_DISCARD;
                    end else begin
                        ram_req.we    = 1'b1;
                        ram_req.waddr = wr_idx_reg + staged_reg;
                        left_next     = left_dec;
                        staged_next   = staged_reg + ADDR_W'(1);
                        status        = ST_STORED;
                        if (left_dec == '0) begin
                            commit     = 1'b1;
                            commit_cnt = staged_reg + ADDR_W'(1);
                        end
                    end
                end
                CMD_TX_DONE: begin
                    if (busy_reg) begin
                        rd_idx_next = rd_idx_reg + size_reg[ADDR_W-1:0];
                        busy_next   = 1'b0;
                        size_next   = '0;
                        retry       = 1'b1;
                    end
                end
                CMD_READ: begin
                    ram_req.re = 1'b1;
                end
                default: begin
                    status = ST_INVALID;
                end
            endcase

            if (commit) begin
                wr_idx_next = wr_idx_reg + commit_cnt;
                staged_next = '0;
                retry       = 1'b1;
            end

            if (retry && tx_en_reg && !busy_next && rd_idx_next != wr_idx_next) begin
                start     = 1'b1;
                busy_next = 1'b1;
                if (wr_idx_next > rd_idx_next) begin
                    size_next = CNT_W'(wr_idx_next - rd_idx_next);
                end else begin
                    size_next = CNT_W'(DEPTH) - CNT_W'(rd_idx_next);
                end
            end
        end

        result.status        = status;
        result.burst_start   = start;
        result.burst_offset  = rd_idx_next;
        result.burst_length  = busy_next ? size_next : '0;
        result.dropped_bytes = drop_next;
        result.used_bytes    = wr_idx_next - rd_idx_next;
        result.is_read       = accept && (cmd_t'(cmd) == CMD_READ);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_idx_reg  <= '0;
            rd_idx_reg  <= '0;
            busy_reg    <= 1'b0;
            size_reg    <= '0;
            drop_reg    <= '0;
            left_reg    <= '0;
            discard_reg <= 1'b0;
            staged_reg  <= '0;
            tx_en_reg   <= 1'b0;
        end else begin
            wr_idx_reg  <= wr_idx_next;
            rd_idx_reg  <= rd_idx_next;
            busy_reg    <= busy_next;
            size_reg    <= size_next;
            drop_reg    <= drop_next;
            left_reg    <= left_next;
            discard_reg <= discard_next;
            staged_reg  <= staged_next;
            if (cfg_write) begin
                tx_en_reg <= cfg_tx_enable;
            end
        end
    end

endmodule

// ===== rtl/tx_ring_burst_queue_core.sv =====
// An accepted item goes to the pending stage, while the synchronous RAM does
//   the ring read of a read command, and then to the output register.
// Throughput: one item per cycle while results are taken; the pending
//   stage and the output register let a new item enter while a result waits.
// Reset: synchronous, active low; clears pointers, counters, tx_enable and
//   both result stages. Ring contents are not cleared.
module tx_ring_burst_queue_core
    import trbq_pkg::*;
(
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                cfg_valid,
    output logic                cfg_ready,
    input  logic [0:0]          cfg_data,
    input  logic                s_valid,
    output logic                s_ready,
    input  logic [1:0]          s_cmd,
    input  logic [BYTE_W-1:0]   s_data_byte,
    input  logic                s_first_of_message,
    input  logic [LEN_W-1:0]    s_message_length,
    input  logic [ADDR_W-1:0]   s_read_offset,
    output logic                m_valid,
    input  logic                m_ready,
    output logic [2:0]          m_status,
    output logic                m_burst_start,
    output logic [ADDR_W-1:0]   m_burst_offset,
    output logic [CNT_W-1:0]    m_burst_length,
    output logic [BYTE_W-1:0]   m_read_byte,
    output logic [DROP_W-1:0]   m_dropped_bytes,
    output logic [ADDR_W-1:0]   m_used_bytes
);

    trbq_ram_req_t     ram_req;
    trbq_result_t      result;
    logic [BYTE_W-1:0] ram_rdata;
    logic              accept;
    logic              advance;

    logic              pend_valid_reg, pend_valid_next;
    trbq_result_t      pend_reg;
    logic              out_valid_reg,  out_valid_next;
    trbq_result_t      out_reg;
    logic [BYTE_W-1:0] out_byte_reg;

    assign cfg_ready = 1'b1;
    assign advance   = pend_valid_reg && (!out_valid_reg || m_ready);
    assign s_ready   = !pend_valid_reg || advance;
    assign accept    = s_valid && s_ready;

    trbq_ctrl u_ctrl (
        .aclk             (aclk),
        .aresetn          (aresetn),
        .cfg_write        (cfg_valid && cfg_ready),
        .cfg_tx_enable    (cfg_data[0]),
        .accept           (accept),
        .cmd              (s_cmd),
        .data_byte        (s_data_byte),
        .first_of_message (s_first_of_message),
        .message_length   (s_message_length),
        .read_offset      (s_read_offset),
        .ram_req          (ram_req),
        .result           (result)
    );

    trbq_ram #(
        .WIDTH (BYTE_W),
        .DEPTH (DEPTH)
    ) u_ring (
        .aclk  (aclk),
        .we    (ram_req.we),
        .waddr (ram_req.waddr),
        .wdata (ram_req.wdata),
        .re    (ram_req.re),
        .raddr (ram_req.raddr),
        .rdata (ram_rdata)
    );

    always_comb begin
        pend_valid_next = pend_valid_reg;
        out_valid_next  = out_valid_reg;
        if (advance) begin
            pend_valid_next = 1'b0;
            out_valid_next  = 1'b1;
        end else if (m_ready) begin
            out_valid_next = 1'b0;
        end
        if (accept) begin
            pend_valid_next = 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pend_valid_reg <= 1'b0;
            out_valid_reg  <= 1'b0;
        end else begin
            pend_valid_reg <= pend_valid_next;
            out_valid_reg  <= out_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (accept) begin
            pend_reg <= result;
        end
        if (advance) begin
            out_reg      <= pend_reg;
            out_byte_reg <= pend_reg.is_read ? ram_rdata : '0;
        end
    end

    assign m_valid         = out_valid_reg;
    assign m_status        = out_reg.status;
    assign m_burst_start   = out_reg.burst_start;
    assign m_burst_offset  = out_reg.burst_offset;
    assign m_burst_length  = out_reg.burst_length;
    assign m_read_byte     = out_byte_reg;
    assign m_dropped_bytes = out_reg.dropped_bytes;
    assign m_used_bytes    = out_reg.used_bytes;

endmodule

// ===== rtl/trbq_checker.sv =====
module trbq_checker
    import trbq_pkg::*;
(
    input logic              aclk,
    input logic              aresetn,
    input logic              m_valid,
    input logic              m_ready,
    input logic [2:0]        m_status,
    input logic              m_burst_start,
    input logic [CNT_W-1:0]  m_burst_length,
    input logic [BYTE_W-1:0] m_read_byte,
    input logic [ADDR_W-1:0] m_used_bytes
);

    // hold a stalled result
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_status))
        else $error("result changed while stalled");

    a_byte_only_done: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_status != ST_DONE |-> m_read_byte == '0)
        else $error("read byte on a non-read result");

    a_start_len: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_burst_start |-> m_burst_length != '0)
        else $error("burst started with zero length");

    a_burst_data: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_burst_length != '0 |-> 32'(m_used_bytes) >= 32'(m_burst_length))
        else $error("active burst exceeds ring contents");

endmodule

bind tx_ring_burst_queue_core trbq_checker u_trbq_checker (
    .aclk           (aclk),
    .aresetn        (aresetn),
    .m_valid        (m_valid),
    .m_ready        (m_ready),
    .m_status       (m_status),
    .m_burst_start  (m_burst_start),
    .m_burst_length (m_burst_length),
    .m_read_byte    (m_read_byte),
    .m_used_bytes   (m_used_bytes)
);
